// ----- src/bf3sat_pkg.sv -----
// Shared constants, types and state codes of the exhaustive 3-SAT checker.
package bf3sat_pkg;

  localparam int MaxVars       = 20;
  localparam int MaxClauses    = 128;
  localparam int VarW          = 5;
  localparam int CntW          = MaxVars + 1;
  localparam int ClauseAddrW   = $clog2(MaxClauses);
  localparam int ClauseTotW    = ClauseAddrW + 1;
  localparam logic [VarW-1:0] VarCountReset = VarW'(10);
  localparam logic [VarW-1:0] VarCountMax   = VarW'(MaxVars);

  typedef struct packed {
    logic [VarW-1:0] vnum;
    logic            pos;
  } lit_t;

  typedef struct packed {
    lit_t lit2;
    lit_t lit1;
    lit_t lit0;
  } clause_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_RESULT
  } state_e;

endpackage

// ----- src/bf3sat_clause_eval.sv -----
// Evaluates one stored clause against the current assignment.
module bf3sat_clause_eval
  import bf3sat_pkg::*;
(
  input  clause_t         clause_i,
  input  logic [CntW-1:0] assign_i,
  output logic            clause_ok_o
);

  function automatic logic lit_true(lit_t lit, logic [CntW-1:0] asg);
    logic [VarW-1:0] bit_idx;
    logic            val;
    bit_idx = lit.vnum - VarW'(1);
    if (lit.vnum == '0) begin
      lit_true = 1'b0;
    end else begin
      val = (32'(bit_idx) < CntW) ? asg[bit_idx] : 1'b0;
      lit_true = (val == lit.pos);
    end
  endfunction

  assign clause_ok_o = lit_true(clause_i.lit0, assign_i) |
                       lit_true(clause_i.lit1, assign_i) |
                       lit_true(clause_i.lit2, assign_i);

endmodule

// ----- src/brute_force_3sat_checker.sv -----
// Top level of the exhaustive 3-SAT checker: clause store, search sequencer, ports.
// Loading takes one cycle per clause word; the word marked last starts the search.
// Each assignment walks the C stored clauses through the one clause evaluator:
// a rejected assignment stops at the clause k that fails, a satisfying one runs all C.
// The result word is valid from the cycle after the search ends and holds until taken.
// Reset is asynchronous, active low: store empty, var_count 10, sequencer loading.
module brute_force_3sat_checker
  import bf3sat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // lit0_var[4:0], lit0_pos[5], lit1_var[10:6], lit1_pos[11], lit2_var[16:12], lit2_pos[17]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // satisfiable[0], assignments_checked[21:1]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e                 state_q, state_d;
  logic [VarW-1:0]        var_count_q;
  logic [ClauseTotW-1:0]  total_cl_q, total_cl_d;
  logic [ClauseTotW-1:0]  idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic                   pend_last_q, pend_last_d;
  logic [CntW-1:0]        assign_q, assign_d;
  logic [CntW-1:0]        limit_q, limit_d;
  logic                   sat_q, sat_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  clause_t                rd_data_q;
  clause_t                mem [MaxClauses];
  clause_t                wr_clause;
  logic                   in_acc, wr_en, issue, clause_ok;
  logic [VarW-1:0]        n_vars;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'b0, var_count_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= VarCountReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      var_count_q <= pwdata[VarW-1:0];
    end
  end

  assign wr_clause.lit0.vnum = s_axis_tdata[4:0];
  assign wr_clause.lit0.pos  = s_axis_tdata[5];
  assign wr_clause.lit1.vnum = s_axis_tdata[10:6];
  assign wr_clause.lit1.pos  = s_axis_tdata[11];
  assign wr_clause.lit2.vnum = s_axis_tdata[16:12];
  assign wr_clause.lit2.pos  = s_axis_tdata[17];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_acc && (total_cl_q < ClauseTotW'(MaxClauses));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[total_cl_q[ClauseAddrW-1:0]] <= wr_clause;
    end
    rd_data_q <= mem[idx_q[ClauseAddrW-1:0]];
  end

  bf3sat_clause_eval u_eval (
    .clause_i    (rd_data_q),
    .assign_i    (assign_q),
    .clause_ok_o (clause_ok)
  );

  always_comb begin
    if (var_count_q == '0) begin
      n_vars = VarW'(1);
    end else if (var_count_q > VarCountMax) begin
      n_vars = VarCountMax;
    end else begin
      n_vars = var_count_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    total_cl_d  = total_cl_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    assign_d    = assign_q;
    limit_d     = limit_q;
    sat_d       = sat_q;
    cnt_d       = cnt_q;
    issue       = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (wr_en) begin
          total_cl_d = total_cl_q + ClauseTotW'(1);
        end
        if (in_acc && s_axis_tlast) begin
          limit_d  = CntW'(1) << n_vars;
          assign_d = '0;
          idx_d    = '0;
          state_d  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        issue       = (idx_q < total_cl_q);
        pend_d      = issue;
        pend_last_d = (idx_q == total_cl_q - ClauseTotW'(1));
        if (issue) begin
          idx_d = idx_q + ClauseTotW'(1);
        end
        if (pend_q && clause_ok && pend_last_q) begin
          sat_d      = 1'b1;
          cnt_d      = assign_q + CntW'(1);
          pend_d     = 1'b0;
          total_cl_d = '0;
          state_d    = ST_RESULT;
        end else if (pend_q && !clause_ok) begin
          pend_d = 1'b0;
          idx_d  = '0;
          if (assign_q + CntW'(1) == limit_q) begin
            sat_d      = 1'b0;
            cnt_d      = limit_q;
            total_cl_d = '0;
            state_d    = ST_RESULT;
          end else begin
            assign_d = assign_q + CntW'(1);
          end
        end
      end
      ST_RESULT: begin
        if (m_axis_tready) begin
          assign_d = '0;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      total_cl_q  <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      assign_q    <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      total_cl_q  <= total_cl_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      assign_q    <= assign_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    cnt_q <= cnt_d;
  end

  assign m_axis_tvalid = (state_q == ST_RESULT);
  assign m_axis_tdata  = {2'b0, cnt_q, sat_q};

endmodule

// ----- src/bf3sat_checker.sv -----
// Port-level assertions for the exhaustive 3-SAT checker and their bind.
module bf3sat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result word dropped before it was taken.");

  a_no_load_during_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("Input accepted while a result is pending.");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:1] != 21'd0))
    else $error("Result reports zero assignments tried.");

  a_unsat_power_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> $onehot(m_axis_tdata[21:1]))
    else $error("Unsatisfiable result does not report the full search space.");

endmodule

bind brute_force_3sat_checker bf3sat_checker u_bf3sat_checker (.*);

// ----- test/tb_brute_force_3sat_checker.sv -----
// Testbench for the exhaustive 3-SAT checker: directed and random formulas checked by a predictor.
module tb_brute_force_3sat_checker;
  import bf3sat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] VarCountAddr = 3'd0;
  localparam int NumPhases   = 9;
  localparam int PhaseItems  = 190;
  localparam int FullPhase   = 4;
  localparam int HoldPhase   = 6;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 40000;
  localparam int NumPlan     = 21;
  localparam int PhaseVars [NumPhases] = '{3, 1, 6, 8, 2, 5, 4, 7, 2};

  typedef struct packed {
    logic            sat;
    logic [CntW-1:0] checked;
  } verdict_t;

  typedef struct packed {
    logic            cfg_en;
    logic [VarW-1:0] cfg_val;
    logic [VarW-1:0] v0;
    logic            p0;
    logic [VarW-1:0] v1;
    logic            p1;
    logic [VarW-1:0] v2;
    logic            p2;
    logic            last;
    logic            known;
    logic            sat;
    logic [CntW-1:0] cnt;
  } plan_row_t;

  // Rows with known set carry a verdict that follows directly from the formula.
  localparam plan_row_t Plan [NumPlan] = '{
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd2,  1'b0, 5'd3,  1'b0, 1'b1, 1'b1, 1'b1, 21'd1},
    '{1'b1, 5'd1,  5'd1,  1'b1, 5'd1,  1'b1, 5'd1,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd1,  1'b0, 5'd1,  1'b0, 1'b1, 1'b1, 1'b0, 21'd2},
    '{1'b1, 5'd20, 5'd20, 1'b1, 5'd1,  1'b1, 5'd1,  1'b1, 1'b1, 1'b1, 1'b1, 21'd2},
    '{1'b1, 5'd31, 5'd1,  1'b1, 5'd2,  1'b1, 5'd3,  1'b1, 1'b1, 1'b1, 1'b1, 21'd2},
    '{1'b1, 5'd0,  5'd1,  1'b1, 5'd1,  1'b1, 5'd1,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd1,  1'b0, 5'd1,  1'b0, 1'b1, 1'b1, 1'b0, 21'd2},
    '{1'b1, 5'd2,  5'd0,  1'b1, 5'd0,  1'b0, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, 21'd4},
    '{1'b0, 5'd0,  5'd31, 1'b1, 5'd21, 1'b1, 5'd3,  1'b1, 1'b1, 1'b1, 1'b0, 21'd4},
    '{1'b0, 5'd0,  5'd31, 1'b0, 5'd30, 1'b1, 5'd25, 1'b1, 1'b1, 1'b1, 1'b1, 21'd1},
    '{1'b1, 5'd4,  5'd1,  1'b1, 5'd2,  1'b1, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd4,  1'b1, 5'd2,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd2,  1'b0, 5'd4,  1'b0, 5'd3,  1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
    '{1'b1, 5'd3,  5'd1,  1'b0, 5'd2,  1'b0, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b1, 5'd2,  1'b0, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd2,  1'b1, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b1, 5'd2,  1'b1, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd2,  1'b0, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b1, 5'd2,  1'b0, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b0, 5'd2,  1'b1, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
    '{1'b0, 5'd0,  5'd1,  1'b1, 5'd2,  1'b1, 5'd3,  1'b1, 1'b1, 1'b1, 1'b0, 21'd8}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // lit0_var[4:0], lit0_pos[5], lit1_var[10:6], lit1_pos[11], lit2_var[16:12], lit2_pos[17]
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // satisfiable[0], assignments_checked[21:1]
  logic [23:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clause_t         clause_mem [MaxClauses];
  int              clauses_held = 0;
  logic [VarW-1:0] var_count_shadow = VarCountReset;
  verdict_t        verdict_q [$];
  int              mismatches = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_seq = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              quiet_cycles = 0;

  brute_force_3sat_checker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int active_vars();
    if (var_count_shadow == '0) return 1;
    if (int'(var_count_shadow) > MaxVars) return MaxVars;
    return int'(var_count_shadow);
  endfunction

  function automatic bit literal_holds(lit_t l, logic [31:0] assign_bits);
    if (l.vnum == '0) return 1'b0;
    return assign_bits[int'(l.vnum) - 1] == l.pos;
  endfunction

  function automatic bit clause_holds(clause_t c, logic [31:0] assign_bits);
    return literal_holds(c.lit0, assign_bits) || literal_holds(c.lit1, assign_bits) ||
           literal_holds(c.lit2, assign_bits);
  endfunction

  // Walks the assignments upward from zero and stops at the first one that
  // satisfies every held clause.
  function automatic verdict_t search_assignments();
    int unsigned total;
    bit          all_hold;
    total = 32'd1 << active_vars();
    for (int unsigned a = 0; a < total; a++) begin
      all_hold = 1'b1;
      for (int i = 0; i < clauses_held; i++) begin
        if (!clause_holds(clause_mem[i], a)) begin
          all_hold = 1'b0;
          break;
        end
      end
      if (all_hold) return '{1'b1, CntW'(a + 1)};
    end
    return '{1'b0, CntW'(total)};
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic send_clause(input clause_t c, input logic last, input bit typed,
                             input verdict_t typed_v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {6'b0, c.lit2.pos, c.lit2.vnum, c.lit1.pos, c.lit1.vnum,
                      c.lit0.pos, c.lit0.vnum};
    do @(posedge clk_i); while (!s_axis_tready);
    if (clauses_held < MaxClauses) begin
      clause_mem[clauses_held] = c;
      clauses_held++;
    end
    if (last) begin
      verdict_q.push_back(typed ? typed_v : search_assignments());
      clauses_held = 0;
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_var_count(input logic [VarW-1:0] val);
    wait_results();
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VarCountAddr;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    var_count_shadow = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[VarW-1:0] !== val)
      report($sformatf("var_count readback: expected %0d, got %0d", val, prdata[VarW-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Most literals name a variable inside the enumerated range; a few take any
  // five-bit value, including variable zero and variables above the count.
  task automatic send_formula(input int n_clauses);
    clause_t c;
    lit_t    l [3];
    for (int k = 0; k < n_clauses; k++) begin
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(9) == 0) l[j].vnum = VarW'($urandom_range(31));
        else l[j].vnum = VarW'($urandom_range(active_vars(), 1));
        l[j].pos = 1'($urandom_range(1));
      end
      c.lit0 = l[0];
      c.lit1 = l[1];
      c.lit2 = l[2];
      send_clause(c, k == n_clauses - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen     <= hold_seq;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        exp_v = verdict_q.pop_front();
        if (m_axis_tdata[0] !== exp_v.sat)
          report($sformatf("satisfiable: expected %0d, got %0d", exp_v.sat, m_axis_tdata[0]));
        if (m_axis_tdata[CntW:1] !== exp_v.checked)
          report($sformatf("assignments_checked: expected %0d, got %0d",
                           exp_v.checked, m_axis_tdata[CntW:1]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("brute_force_3sat_checker: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clause_t  c;
    verdict_t typed_v;
    int       left;
    int       n_clauses;
    bit       paused;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct <= 66;
    for (int r = 0; r < NumPlan; r++) begin
      if (Plan[r].cfg_en) write_var_count(Plan[r].cfg_val);
      c.lit0  = '{Plan[r].v0, Plan[r].p0};
      c.lit1  = '{Plan[r].v1, Plan[r].p1};
      c.lit2  = '{Plan[r].v2, Plan[r].p2};
      typed_v = '{Plan[r].sat, Plan[r].cnt};
      send_clause(c, Plan[r].last, Plan[r].known, typed_v);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = (ph < 3) ? 36 : (ph < 6) ? 66 : 0;
      recv_idle_pct <= (ph < 3) ? 66 : (ph < 6) ? 36 : 0;
      write_var_count(VarW'(PhaseVars[ph]));
      if (ph == HoldPhase) hold_seq <= hold_seq + 1;
      // Overfills the clause store so the extra clauses are dropped.
      if (ph == FullPhase) send_formula(MaxClauses + 2);
      left   = PhaseItems;
      paused = 1'b0;
      while (left > 0) begin
        if ($urandom_range(9) == 0) n_clauses = $urandom_range(20, 7);
        else n_clauses = $urandom_range(6, 1);
        if (n_clauses > left) n_clauses = left;
        send_formula(n_clauses);
        left -= n_clauses;
        if (!paused && left < PhaseItems / 2) begin
          wait_results();
          paused = 1'b1;
        end
      end
    end

    wait_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("brute_force_3sat_checker: match");
    end else begin
      $display("brute_force_3sat_checker: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bf3sat_pkg.sv
src/bf3sat_clause_eval.sv
src/brute_force_3sat_checker.sv
src/bf3sat_checker.sv
test/tb_brute_force_3sat_checker.sv
